// File: rtl/core/msa_rle_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// msa_rle_pkg
// Shared types and constants of the track run-length decoder.
// ============================================================================
package msa_rle_pkg;

    // Escape byte that opens a run, and the slack allowed past the track size.
    localparam logic [7:0] ESCAPE_BYTE  = 8'hE5;
    localparam int         SLACK_BYTES  = 8;

    // Defaults for the top-level parameters.
    localparam int MAX_SECTORS_DEF  = 32;
    localparam int SECTOR_BYTES_DEF = 512;

    // Configuration port.
    localparam int         CFG_W         = 6;
    localparam int         PADDR_W       = 2;
    localparam int         PDATA_W       = 32;
    localparam logic [1:0] REG_SECTORS   = 2'd0;
    localparam logic [5:0] SECTORS_RESET = 6'd9;

    // Decoder phase: which byte of the record is expected next.
    typedef enum logic [1:0] {
        PH_LITERAL  = 2'd0,
        PH_VALUE    = 2'd1,
        PH_COUNT_HI = 2'd2,
        PH_COUNT_LO = 2'd3
    } phase_t;

    // Track status carried by each result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_CUTOFF   = 2'd2,
        ST_SHORT    = 2'd3
    } status_t;

    // One byte of a track record.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_track;
        logic       stored_raw;
    } in_item_t;

    // Outcome of one decode step.
    typedef struct packed {
        logic        have;
        logic [7:0]  run_value;
        logic [15:0] run_length;
        logic        track_done;
        status_t     status;
    } step_result_t;

endpackage

// File: rtl/core/msa_rle_ifs.sv
`timescale 1ns / 1ps
// ============================================================================
// msa_rle_ifs
// Valid/ready channels for record bytes in and decoded runs out.
// ============================================================================
interface msa_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_track;
    logic       stored_raw;

    modport source (output valid, output data_byte, output end_of_track,
                    output stored_raw, input ready);
    modport sink   (input valid, input data_byte, input end_of_track,
                    input stored_raw, output ready);
endinterface

interface msa_rle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  run_value;
    logic [15:0] run_length;
    logic        track_done;
    logic [1:0]  status;

    modport source (output valid, output run_value, output run_length,
                    output track_done, output status, input ready);
    modport sink   (input valid, input run_value, input run_length,
                    input track_done, input status, output ready);
endinterface

// File: rtl/core/msa_rle_core.sv
`timescale 1ns / 1ps
// ============================================================================
// msa_rle_core
// Per-track decoder state and the single-pass step that updates it.
// ============================================================================
module msa_rle_core #(
    parameter int MAX_SECTORS  = 32,
    parameter int SECTOR_BYTES = 512
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  msa_rle_pkg::in_item_t      item,
    input  logic [msa_rle_pkg::CFG_W-1:0] sectors,
    output msa_rle_pkg::step_result_t  result
);
    import msa_rle_pkg::*;

    localparam int LIMIT_MAX = MAX_SECTORS * SECTOR_BYTES + SLACK_BYTES;
    localparam int TRACK_W   = $clog2(LIMIT_MAX + 1);
    localparam int SECT_W    = $clog2(MAX_SECTORS + 1);
    localparam int WIDE_W    = (TRACK_W > 16) ? TRACK_W : 16;

    phase_t               phase_reg, phase_next;
    logic [7:0]           held_value_reg, held_value_next;
    logic [7:0]           count_high_reg, count_high_next;
    logic [TRACK_W-1:0]   bytes_produced_reg, bytes_produced_next;
    logic                 overflowed_reg, overflowed_next;

    logic [6:0]           sect_wide;
    logic [SECT_W-1:0]    sect_eff;
    logic [TRACK_W-1:0]   track_size;
    logic [TRACK_W-1:0]   limit;
    logic [TRACK_W-1:0]   room;
    logic                 have;
    logic [7:0]           val;
    logic [WIDE_W-1:0]    len_wide;
    logic [WIDE_W-1:0]    sum_wide;

    // Clamp the register to the supported sector range.
    always_comb
    begin
        sect_wide = {1'b0, sectors};
        if (sect_wide == 7'd0)
        begin
            sect_eff = SECT_W'(1);
        end
        else if (sect_wide > 7'(MAX_SECTORS))
        begin
            sect_eff = SECT_W'(MAX_SECTORS);
        end
        else
        begin
            sect_eff = SECT_W'(sect_wide);
        end
        track_size = TRACK_W'(sect_eff) * TRACK_W'(SECTOR_BYTES);
        limit      = track_size + TRACK_W'(SLACK_BYTES);
        room       = (bytes_produced_reg < limit) ? (limit - bytes_produced_reg)
                                                  : '0;
    end

    always_comb
    begin
        phase_next          = phase_reg;
        held_value_next     = held_value_reg;
        count_high_next     = count_high_reg;
        bytes_produced_next = bytes_produced_reg;
        overflowed_next     = overflowed_reg;
        have                = 1'b0;
        val                 = 8'd0;
        len_wide            = '0;
        sum_wide            = '0;

        if (!overflowed_reg)
        begin
            case (phase_reg)
                PH_LITERAL:
                begin
                    if (!item.stored_raw && item.data_byte == ESCAPE_BYTE)
                    begin
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        have     = 1'b1;
                        val      = item.data_byte;
                        len_wide = WIDE_W'(1);
                    end
                end
                PH_VALUE:
                begin
                    held_value_next = item.data_byte;
                    phase_next      = PH_COUNT_HI;
                end
                PH_COUNT_HI:
                begin
                    count_high_next = item.data_byte;
                    phase_next      = PH_COUNT_LO;
                end
                default:
                begin
                    have       = 1'b1;
                    val        = held_value_reg;
                    len_wide   = WIDE_W'({count_high_reg, item.data_byte});
                    phase_next = PH_LITERAL;
                end
            endcase

            if (have)
            begin
                // Clip the run so that the track ends exactly at the limit.
                if (len_wide >= WIDE_W'(room))
                begin
                    len_wide        = WIDE_W'(room);
                    overflowed_next = 1'b1;
                end
                sum_wide            = WIDE_W'(bytes_produced_reg) + len_wide;
                bytes_produced_next = sum_wide[TRACK_W-1:0];
            end
        end

        result.have       = have || item.end_of_track;
        result.run_value  = val;
        result.run_length = len_wide[15:0];
        result.track_done = item.end_of_track;
        result.status     = overflowed_next ? ST_OVERFLOW : ST_OK;

        if (item.end_of_track)
        begin
            if (overflowed_next)
            begin
                result.status = ST_OVERFLOW;
            end
            else if (phase_next != PH_LITERAL)
            begin
                result.status = ST_CUTOFF;
            end
            else if (bytes_produced_next < track_size)
            begin
                result.status = ST_SHORT;
            end
            else
            begin
                result.status = ST_OK;
            end
            phase_next          = PH_LITERAL;
            held_value_next     = 8'd0;
            count_high_next     = 8'd0;
            bytes_produced_next = '0;
            overflowed_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_LITERAL;
            held_value_reg     <= 8'd0;
            count_high_reg     <= 8'd0;
            bytes_produced_reg <= '0;
            overflowed_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg          <= phase_next;
            held_value_reg     <= held_value_next;
            count_high_reg     <= count_high_next;
            bytes_produced_reg <= bytes_produced_next;
            overflowed_reg     <= overflowed_next;
        end
    end

endmodule

// File: rtl/core/msa_track_rle_decoder_top.sv
`timescale 1ns / 1ps
// ============================================================================
// msa_track_rle_decoder_top
// Escape-byte run-length decoder of floppy tracks, a byte a cycle if unstalled.
// ============================================================================
//
//  Channel   Dir   Handshake          Request carries
//  --------  ----  -----------------  -----------------------------------------
//  in_ch     in    valid / ready      data_byte, end_of_track, stored_raw
//  out_ch    out   valid / ready      run_value, run_length, track_done, status
//  APB       in    psel / penable     sectors_per_track at byte address 0
//
// One record byte is accepted every cycle while out_ch is not stalled. A
// byte sits in the input register, where the decode step updates the track
// state, and the run it produces is loaded into the output register, from
// which out_ch takes it. rst_n clears the track state, the valid flags and
// sets sectors_per_track to 9. When out_ch is stalled with a result held,
// the input register holds too and in_ch.ready drops only if that register
// is also occupied.
//
module msa_track_rle_decoder_top #(
    parameter int MAX_SECTORS  = msa_rle_pkg::MAX_SECTORS_DEF,
    parameter int SECTOR_BYTES = msa_rle_pkg::SECTOR_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msa_rle_pkg::PADDR_W-1:0] paddr,
    input  logic [msa_rle_pkg::PDATA_W-1:0] pwdata,
    output logic [msa_rle_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    msa_rle_in_if.sink                    in_ch,
    msa_rle_out_if.source                 out_ch
);
    import msa_rle_pkg::*;

    // Configuration register: written on the access phase of an APB write.
    logic [CFG_W-1:0] sectors_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_SECTORS);
    assign prdata    = (paddr == REG_SECTORS) ? PDATA_W'(sectors_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sectors_reg <= SECTORS_RESET;
        end
        else if (cfg_write)
        begin
            sectors_reg <= pwdata[CFG_W-1:0];
        end
    end

    // The whole pipeline moves whenever the output register is free or its
    // result is being taken this cycle.
    logic         advance;
    logic         in_fire;
    logic         step_en;
    logic         s1_valid_reg, s1_valid_next;
    in_item_t     s1_item_reg;
    step_result_t step_res;
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_value_reg;
    logic [15:0]  out_length_reg;
    logic         out_done_reg;
    status_t      out_status_reg;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign step_en     = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step_en && step_res.have;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.data_byte    <= in_ch.data_byte;
            s1_item_reg.end_of_track <= in_ch.end_of_track;
            s1_item_reg.stored_raw   <= in_ch.stored_raw;
        end
        if (step_en && step_res.have)
        begin
            out_value_reg  <= step_res.run_value;
            out_length_reg <= step_res.run_length;
            out_done_reg   <= step_res.track_done;
            out_status_reg <= step_res.status;
        end
    end

    // The decode step and the per-track state it owns.
    msa_rle_core #(
        .MAX_SECTORS  (MAX_SECTORS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (s1_item_reg),
        .sectors (sectors_reg),
        .result  (step_res)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.run_value  = out_value_reg;
    assign out_ch.run_length = out_length_reg;
    assign out_ch.track_done = out_done_reg;
    assign out_ch.status     = out_status_reg;

    // Results before the end of a track can only report ok or overflow.
    a_mid_status : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_done_reg |->
            (out_status_reg == ST_OK || out_status_reg == ST_OVERFLOW))
        else $error("mid-track result carries a final-only status");

    // A cut-off escape never delivers data with its final result.
    a_cutoff_empty : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_CUTOFF |->
            (out_done_reg && out_length_reg == 16'd0 && out_value_reg == 8'd0))
        else $error("cut-off escape result carries data");

    // The input side stalls only behind a held, untaken result.
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s1_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("input stalled without a blocked result");

endmodule
